// ===== sv/oal_pkg.sv =====
// Shared types and constants for the ordered array list.
package oal_pkg;

  localparam int unsigned DepthDef       = 16;
  localparam int unsigned PayloadBitsDef = 32;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned PosW    = 5;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned PayInW  = 32;
  localparam int unsigned FoundW  = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned InDataW = 72;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [2:0] {
    MODE_INSERT     = 3'd0,
    MODE_APPEND     = 3'd1,
    MODE_REMOVE_AT  = 3'd2,
    MODE_REMOVE_KEY = 3'd3,
    MODE_FIND       = 3'd4,
    MODE_CLEAR      = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_cmd_e;

endpackage

// ===== sv/oal_cell.sv =====
// One list cell: holds one key/payload entry, shifts with its neighbors, compares its key.
module oal_cell
  import oal_pkg::*;
#(
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic                    clk_i,
  input  cell_cmd_e               cmd_i,
  input  logic [KeyW-1:0]         new_key_i,
  input  logic [PAYLOAD_BITS-1:0] new_pay_i,
  input  logic [KeyW-1:0]         left_key_i,
  input  logic [PAYLOAD_BITS-1:0] left_pay_i,
  input  logic [KeyW-1:0]         right_key_i,
  input  logic [PAYLOAD_BITS-1:0] right_pay_i,
  input  logic [KeyW-1:0]         search_key_i,
  output logic [KeyW-1:0]         key_o,
  output logic [PAYLOAD_BITS-1:0] pay_o,
  output logic                    match_o
);

  logic [KeyW-1:0]         key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    case (cmd_i)
      CELL_LOAD: begin
        key_d = new_key_i;
        pay_d = new_pay_i;
      end
      CELL_LEFT: begin
        key_d = left_key_i;
        pay_d = left_pay_i;
      end
      CELL_RIGHT: begin
        key_d = right_key_i;
        pay_d = right_pay_i;
      end
      default: begin
        key_d = key_q;
        pay_d = pay_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o   = key_q;
  assign pay_o   = pay_q;
  assign match_o = (key_q == search_key_i);

endmodule

// ===== sv/ordered_array_list.sv =====
// Top level of the ordered array list: command decode, cell row, fill count, result register.
//
//  channel | direction | tdata fields, lowest bit first
//  s_axis  | in        | mode[2:0] position[7:3] key_value[39:8] payload[71:40]
//  m_axis  | out       | ok[0] found_index[4:1] count[9:5], zero pad to 16 bits
//
//  One item per cycle while m_axis is not stalled: every cell shifts, loads or compares in the same cycle.
//  Each item gives one result in the cycle after it is accepted.
//  The result register holds while m_axis is stalled; s_axis takes an item
//  whenever that register is empty or is being emptied in the same cycle.
//  Reset empties the list and the result register.
module ordered_array_list
  import oal_pkg::*;
#(
  parameter int unsigned DEPTH        = DepthDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // mode, position, key_value, payload
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // ok, found_index, count, zero pad
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CmpW  = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned PayXW = (PAYLOAD_BITS > PayInW) ? PAYLOAD_BITS : PayInW;

  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    out_valid_q;
  logic                    ok_q, ok_d;
  logic [FoundW-1:0]       found_q, found_d;
  logic [CountW-1:0]       count_q;

  logic                    in_acc;
  mode_e                   mode;
  logic [PosW-1:0]         position;
  logic [KeyW-1:0]         key_value;
  logic [PayInW-1:0]       payload;
  logic [PayXW-1:0]        pay_ext;
  logic [PAYLOAD_BITS-1:0] new_pay;

  logic [CmpW-1:0]         pos_c, cnt_c, tgt;
  logic                    full, do_ins, do_rem;
  logic                    hit;
  logic [IdxW-1:0]         hit_idx;
  logic [CmpW-1:0]         hit_c;

  logic [KeyW-1:0]         cell_key [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];
  logic [DEPTH-1:0]        cell_match;
  cell_cmd_e               cell_cmd [DEPTH];

  assign mode      = mode_e'(s_axis_tdata_i[2:0]);
  assign position  = s_axis_tdata_i[7:3];
  assign key_value = s_axis_tdata_i[39:8];
  assign payload   = s_axis_tdata_i[71:40];
  assign pay_ext   = PayXW'(payload);
  assign new_pay   = pay_ext[PAYLOAD_BITS-1:0];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign pos_c = CmpW'(position);
  assign cnt_c = CmpW'(cnt_q);
  assign full  = (cnt_q == CntW'(DEPTH));

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_match[i] && (CmpW'(i) < cnt_c)) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  assign hit_c = CmpW'(hit_idx);

  always_comb begin
    cnt_d   = cnt_q;
    ok_d    = 1'b0;
    found_d = '0;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    tgt     = pos_c;
    case (mode)
      MODE_INSERT: begin
        do_ins = !full && (pos_c <= cnt_c);
      end
      MODE_APPEND: begin
        tgt    = cnt_c;
        do_ins = !full;
      end
      MODE_REMOVE_AT: begin
        do_rem = (pos_c < cnt_c);
      end
      MODE_REMOVE_KEY: begin
        tgt    = hit_c;
        do_rem = hit;
      end
      MODE_FIND: begin
        ok_d    = hit;
        found_d = hit ? hit_c[FoundW-1:0] : '0;
      end
      MODE_CLEAR: begin
        ok_d  = 1'b1;
        cnt_d = '0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (do_ins) begin
      ok_d  = 1'b1;
      cnt_d = cnt_q + CntW'(1);
    end
    if (do_rem) begin
      ok_d  = 1'b1;
      cnt_d = cnt_q - CntW'(1);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KeyW-1:0]         left_key, right_key;
    logic [PAYLOAD_BITS-1:0] left_pay, right_pay;

    if (g == 0) begin : g_first
      assign left_key = key_value;
      assign left_pay = new_pay;
    end else begin : g_mid_l
      assign left_key = cell_key[g-1];
      assign left_pay = cell_pay[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_key = cell_key[g];
      assign right_pay = cell_pay[g];
    end else begin : g_mid_r
      assign right_key = cell_key[g+1];
      assign right_pay = cell_pay[g+1];
    end

    always_comb begin
      cell_cmd[g] = CELL_HOLD;
      if (in_acc && do_ins) begin
        if (CmpW'(g) == tgt) begin
          cell_cmd[g] = CELL_LOAD;
        end else if (CmpW'(g) > tgt) begin
          cell_cmd[g] = CELL_LEFT;
        end
      end else if (in_acc && do_rem && (CmpW'(g) >= tgt)) begin
        cell_cmd[g] = CELL_RIGHT;
      end
    end

    oal_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cell_cmd[g]),
      .new_key_i   (key_value),
      .new_pay_i   (new_pay),
      .left_key_i  (left_key),
      .left_pay_i  (left_pay),
      .right_key_i (right_key),
      .right_pay_i (right_pay),
      .search_key_i(key_value),
      .key_o       (cell_key[g]),
      .pay_o       (cell_pay[g]),
      .match_o     (cell_match[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ok_q    <= ok_d;
      found_q <= found_d;
      count_q <= CountW'(cnt_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, count_q, found_q, ok_q};

endmodule
